### rtl/life_grid_generation_step_assert.svh
// Assertion macros shared by the grid stepper modules.
// Both sample on clk_i and are switched off while rst_ni is low.
`ifndef LIFE_GRID_GENERATION_STEP_ASSERT_SVH
`define LIFE_GRID_GENERATION_STEP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LGS_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("grid stepper assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LGS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("grid stepper assertion failed");

`endif

### rtl/lgs_pkg.sv
`default_nettype none

package lgs_pkg;

  // Request kinds carried in req_type and echoed in ack_kind.
  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_READ    = 2'd1,
    REQ_ADVANCE = 2'd2,
    REQ_UNKNOWN = 2'd3
  } req_kind_e;

  // Input payload of one transfer.
  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] row;
    logic [4:0] col;
    logic       cell_in;
  } life_req_t;

  // Output payload of one transfer.
  typedef struct packed {
    logic       cell_out;
    logic [1:0] ack_kind;
  } life_rsp_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_CELL_USE,
    ST_ADV_LOAD,
    ST_ADV_REQ,
    ST_ADV_CALC,
    ST_RESP
  } state_e;

  // Source of the row memory read address.
  typedef enum logic [1:0] {
    ADDR_REQ,
    ADDR_CNT,
    ADDR_CNT_NEXT
  } addr_sel_e;

  // What is written into the row memory.
  typedef enum logic [1:0] {
    WR_NONE,
    WR_CLEAR,
    WR_CELL,
    WR_LIFE
  } wr_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      take_req;
    logic      cnt_rst;
    logic      cnt_inc;
    logic      rd_en;
    addr_sel_e rd_sel;
    wr_op_e    wr_op;
    logic      adv_load;
    logic      adv_shift;
    logic      cell_grab;
    logic      out_load;
  } lgs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    req_kind_e kind;
    logic      in_grid;
    logic      cnt_last;
  } lgs_sts_t;

  // Rule B3/S23 for one cell given its eight neighbours.
  function automatic logic life_rule(input logic alive, input logic [7:0] nbrs);
    logic [3:0] cnt;
    cnt = '0;
    for (int k = 0; k < 8; k++) begin
      cnt = cnt + {3'b000, nbrs[k]};
    end
    return (cnt == 4'd3) || ((cnt == 4'd2) && alive);
  endfunction

endpackage

`default_nettype wire

### rtl/life_grid_generation_step.sv
// Sequence: an in-range write or read goes through dispatch, cell use and response; an
// unknown kind or off-grid index skips cell use; an advance loads the first row, then
// requests and computes each row in turn. One request at a time; the next is taken the
// cycle after the result is registered, which waits while an unread result is held.
// Reset: asynchronous, active low; afterwards a clearing pass writes one dead row per
// cycle through all GRID_SIZE rows, and no request is taken until it has finished.
`default_nettype none

module life_grid_generation_step import lgs_pkg::*; #(
  parameter int GRID_SIZE = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire life_req_t in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output life_rsp_t      out_data_o
);

  lgs_cmd_t cmd;
  lgs_sts_t sts;

  // Sequencer for requests, the clearing pass and the row sweep.
  lgs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Row memory, row window and result register.
  lgs_datapath #(
    .GRID_SIZE (GRID_SIZE)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

### rtl/lgs_ram.sv
`default_nettype none

module lgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/lgs_datapath.sv
`default_nettype none

module lgs_datapath import lgs_pkg::*; #(
  parameter int GRID_SIZE = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire lgs_cmd_t  cmd_i,
  input  wire life_req_t in_data_i,
  output lgs_sts_t       sts_o,
  output life_rsp_t      out_data_o
);

  localparam int ROW_W = $clog2(GRID_SIZE);

  life_req_t              req_q;
  logic [ROW_W-1:0]       cnt_q, cnt_d;
  logic [GRID_SIZE-1:0]   above_q, cur_q;
  logic                   cell_q;
  life_rsp_t              out_q;

  logic [ROW_W-1:0]       req_row, req_col;
  logic                   in_grid;
  logic                   cnt_last;
  logic                   rd_en;
  logic [ROW_W-1:0]       rd_addr;
  logic [GRID_SIZE-1:0]   rd_data;
  logic                   wr_en;
  logic [ROW_W-1:0]       wr_addr;
  logic [GRID_SIZE-1:0]   wr_data;
  logic [GRID_SIZE-1:0]   cell_row;
  logic [GRID_SIZE-1:0]   below;
  logic [GRID_SIZE-1:0]   next_row;
  logic [GRID_SIZE+1:0]   a_pad, c_pad, b_pad;

  // Address decode of the held request.
  assign req_row  = ROW_W'(req_q.row);
  assign req_col  = ROW_W'(req_q.col);
  assign in_grid  = (int'(req_q.row) < GRID_SIZE) && (int'(req_q.col) < GRID_SIZE);
  assign cnt_last = (cnt_q == ROW_W'(GRID_SIZE - 1));

  assign sts_o.kind     = req_kind_e'(req_q.req_type);
  assign sts_o.in_grid  = in_grid;
  assign sts_o.cnt_last = cnt_last;

  // Row below the one being computed; past the last row it is dead.
  assign below = cnt_last ? '0 : rd_data;

  // Next generation of one whole row from the three old rows around it.
  assign a_pad = {1'b0, above_q, 1'b0};
  assign c_pad = {1'b0, cur_q, 1'b0};
  assign b_pad = {1'b0, below, 1'b0};

  always_comb begin
    for (int j = 0; j < GRID_SIZE; j++) begin
      next_row[j] = life_rule(cur_q[j], {a_pad[j], a_pad[j+1], a_pad[j+2],
                                         c_pad[j], c_pad[j+2],
                                         b_pad[j], b_pad[j+1], b_pad[j+2]});
    end
  end

  // Read-modify-write row for a single cell write.
  always_comb begin
    cell_row          = rd_data;
    cell_row[req_col] = req_q.cell_in;
  end

  // Read address selection.
  always_comb begin
    rd_en = cmd_i.rd_en;
    case (cmd_i.rd_sel)
      ADDR_REQ:      rd_addr = req_row;
      ADDR_CNT:      rd_addr = cnt_q;
      ADDR_CNT_NEXT: rd_addr = cnt_q + 1'b1;
      default:       rd_addr = cnt_q;
    endcase
  end

  // Write port selection.
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = cnt_q;
    wr_data = '0;
    case (cmd_i.wr_op)
      WR_NONE:  wr_en = 1'b0;
      WR_CLEAR: wr_data = '0;
      WR_CELL: begin
        wr_addr = req_row;
        wr_data = cell_row;
      end
      WR_LIFE:  wr_data = next_row;
      default:  wr_en = 1'b0;
    endcase
  end

  lgs_ram #(
    .WIDTH (GRID_SIZE),
    .DEPTH (GRID_SIZE)
  ) u_rows (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Row counter used by the clearing pass and by an advance.
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_rst) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Payload registers: request, row window, read cell and result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_req) begin
      req_q <= in_data_i;
    end
    if (cmd_i.adv_load) begin
      above_q <= '0;
      cur_q   <= rd_data;
    end else if (cmd_i.adv_shift) begin
      above_q <= cur_q;
      cur_q   <= below;
    end
    if (cmd_i.cell_grab) begin
      cell_q <= rd_data[req_col];
    end
    if (cmd_i.out_load) begin
      out_q.cell_out <= (req_q.req_type == REQ_READ) && in_grid && cell_q;
      out_q.ack_kind <= req_q.req_type;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

### rtl/lgs_ctrl.sv
`default_nettype none
`include "life_grid_generation_step_assert.svh"

module lgs_ctrl import lgs_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire lgs_sts_t sts_i,
  output lgs_cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.cnt_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (sts_i.kind)
          REQ_WRITE, REQ_READ: state_d = sts_i.in_grid ? ST_CELL_USE : ST_RESP;
          REQ_ADVANCE:         state_d = ST_ADV_LOAD;
          default:             state_d = ST_RESP;
        endcase
      end
      ST_CELL_USE: state_d = ST_RESP;
      ST_ADV_LOAD: state_d = ST_ADV_REQ;
      ST_ADV_REQ:  state_d = ST_ADV_CALC;
      ST_ADV_CALC: begin
        state_d = sts_i.cnt_last ? ST_RESP : ST_ADV_REQ;
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o = '{take_req: 1'b0, cnt_rst: 1'b0, cnt_inc: 1'b0, rd_en: 1'b0,
              rd_sel: ADDR_CNT, wr_op: WR_NONE, adv_load: 1'b0,
              adv_shift: 1'b0, cell_grab: 1'b0, out_load: 1'b0};
    case (state_q)
      ST_CLEAR: begin
        cmd_o.wr_op   = WR_CLEAR;
        cmd_o.cnt_inc = 1'b1;
      end
      ST_IDLE: begin
        cmd_o.take_req = accept;
        cmd_o.cnt_rst  = accept;
      end
      ST_DISPATCH: begin
        case (sts_i.kind)
          REQ_WRITE, REQ_READ: begin
            cmd_o.rd_en  = sts_i.in_grid;
            cmd_o.rd_sel = ADDR_REQ;
          end
          REQ_ADVANCE: begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = ADDR_CNT;
          end
          default: cmd_o.rd_en = 1'b0;
        endcase
      end
      ST_CELL_USE: begin
        cmd_o.cell_grab = 1'b1;
        if (sts_i.kind == REQ_WRITE) cmd_o.wr_op = WR_CELL;
      end
      ST_ADV_LOAD: cmd_o.adv_load = 1'b1;
      ST_ADV_REQ: begin
        cmd_o.rd_en  = !sts_i.cnt_last;
        cmd_o.rd_sel = ADDR_CNT_NEXT;
      end
      ST_ADV_CALC: begin
        cmd_o.wr_op     = WR_LIFE;
        cmd_o.adv_shift = 1'b1;
        cmd_o.cnt_inc   = !sts_i.cnt_last;
      end
      ST_RESP: cmd_o.out_load = !out_valid_q || out_ready_i;
      default: cmd_o.rd_en = 1'b0;
    endcase
  end

  // Output slot occupancy.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // An accepted transfer always takes the controller out of idle.
  `LGS_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != ST_IDLE)
  // A single cell is only written for an in-range write request.
  `LGS_ASSERT_SAME(a_cell_write_ok, cmd_o.wr_op == WR_CELL,
                   sts_i.in_grid && (sts_i.kind == REQ_WRITE))
  // The result register is never overwritten while it still holds a result.
  `LGS_ASSERT_SAME(a_out_slot_free, cmd_o.out_load, !out_valid_q || out_ready_i)

endmodule

`default_nettype wire

### verif/life_grid_generation_step_tb.sv
`timescale 1ns / 1ps

module life_grid_generation_step_tb;
  import lgs_pkg::*;

  localparam int GRID_SIZE = 32;
  // Each random phase carries about a quarter of the random requests.
  localparam int PHASE_REQS = 100;
  // Ample for every request being an advance with long stalls on both sides.
  localparam longint TIMEOUT_NS = 64'd30_000_000;

  // Tracks the grid as it should be and the acknowledgements still owed.
  class life_grid_tracker;
    bit [GRID_SIZE-1:0] cells [GRID_SIZE];
    life_rsp_t expected_acks [$];
    int unsigned failures;

    function new();
      foreach (cells[r]) cells[r] = '0;
      failures = 0;
    endfunction

    // Next generation under B3/S23, with everything beyond the border dead.
    function void step_generation();
      bit [GRID_SIZE-1:0] old_cells [GRID_SIZE];
      int r, c, dr, dc, nr, nc, live;
      old_cells = cells;
      for (r = 0; r < GRID_SIZE; r++) begin
        for (c = 0; c < GRID_SIZE; c++) begin
          live = 0;
          for (dr = -1; dr <= 1; dr++) begin
            for (dc = -1; dc <= 1; dc++) begin
              nr = r + dr;
              nc = c + dc;
              if ((dr != 0 || dc != 0) && nr >= 0 && nc >= 0 &&
                  nr < GRID_SIZE && nc < GRID_SIZE) begin
                live += old_cells[nr][nc];
              end
            end
          end
          cells[r][c] = (live == 3) || (live == 2 && old_cells[r][c]);
        end
      end
    endfunction

    // Applies an accepted request and queues the acknowledgement it owes.
    function void note_request(life_req_t req);
      life_rsp_t ack;
      bit on_grid;
      on_grid = (req.row < GRID_SIZE) && (req.col < GRID_SIZE);
      ack.cell_out = 1'b0;
      ack.ack_kind = req.req_type;
      case (req_kind_e'(req.req_type))
        REQ_WRITE: begin
          if (on_grid) cells[req.row][req.col] = req.cell_in;
        end
        REQ_READ: begin
          if (on_grid) ack.cell_out = cells[req.row][req.col];
        end
        REQ_ADVANCE: begin
          step_generation();
        end
        default: begin
        end
      endcase
      expected_acks.push_back(ack);
    endfunction

    // Compares a delivered acknowledgement with the oldest one owed.
    function void check_ack(life_rsp_t got);
      life_rsp_t want;
      if (expected_acks.size() == 0) begin
        $error("acknowledgement with none expected: cell_out %0d ack_kind %0d",
               got.cell_out, got.ack_kind);
        failures++;
        return;
      end
      want = expected_acks.pop_front();
      if (got.cell_out !== want.cell_out) begin
        $error("cell_out: expected %0d, actual %0d", want.cell_out, got.cell_out);
        failures++;
      end
      if (got.ack_kind !== want.ack_kind) begin
        $error("ack_kind: expected %0d, actual %0d", want.ack_kind, got.ack_kind);
        failures++;
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  life_req_t in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  life_rsp_t out_data_o;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int sent_reqs = 0;
  int idle_by_phase [4] = '{0, 62, 0, 23};
  int stall_by_phase [4] = '{0, 0, 62, 23};

  life_grid_tracker grid_tracker;

  life_grid_generation_step #(
    .GRID_SIZE(GRID_SIZE)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Every result transfer is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) grid_tracker.check_ack(out_data_o);
  end

  function automatic life_req_t req_of(req_kind_e kind, int row, int col, bit value);
    life_req_t req;
    req.req_type = kind;
    req.row      = 5'(row);
    req.col      = 5'(col);
    req.cell_in  = value;
    return req;
  endfunction

  // Offers one request, idling first at random, and waits for its transfer.
  task automatic send_request(input life_req_t req);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    grid_tracker.note_request(req);
    sent_reqs++;
  endtask

  // Seeds a small patch somewhere on the grid, lets it evolve and probes it.
  task automatic run_episode();
    int base_r, base_c, span, n_writes, n_gens, n_reads, k, g;
    base_r   = $urandom_range(31);
    base_c   = $urandom_range(31);
    span     = $urandom_range(3, 8);
    n_writes = $urandom_range(3, 2 * span);
    for (k = 0; k < n_writes; k++) begin
      send_request(req_of(REQ_WRITE, base_r + $urandom_range(span - 1),
                          base_c + $urandom_range(span - 1), $urandom_range(99) < 60));
    end
    n_gens = $urandom_range(1, 3);
    for (g = 0; g < n_gens; g++) begin
      send_request(req_of(REQ_ADVANCE, $urandom_range(31), $urandom_range(31),
                          $urandom_range(1)));
      n_reads = $urandom_range(1, 4);
      for (k = 0; k < n_reads; k++) begin
        send_request(req_of(REQ_READ, base_r + $urandom_range(span - 1),
                            base_c + $urandom_range(span - 1), $urandom_range(1)));
      end
    end
    // Occasional noise: an unknown kind or a stray access anywhere.
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(2))
        0: send_request(req_of(REQ_UNKNOWN, $urandom_range(31), $urandom_range(31),
                               $urandom_range(1)));
        1: send_request(req_of(REQ_WRITE, $urandom_range(31), $urandom_range(31),
                               $urandom_range(1)));
        default: send_request(req_of(REQ_READ, $urandom_range(31), $urandom_range(31),
                                     $urandom_range(1)));
      endcase
    end
  endtask

  initial begin
    int phase, phase_goal;
    grid_tracker = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: cleared grid, a blinker on the top border, a block in the
    // bottom right corner, an unknown kind, a dead write and a birth at a corner.
    send_request(req_of(REQ_READ, 0, 0, 1'b1));
    send_request(req_of(REQ_READ, 31, 31, 1'b0));
    send_request(req_of(REQ_WRITE, 0, 0, 1'b1));
    send_request(req_of(REQ_WRITE, 0, 1, 1'b1));
    send_request(req_of(REQ_WRITE, 0, 2, 1'b1));
    send_request(req_of(REQ_WRITE, 30, 30, 1'b1));
    send_request(req_of(REQ_WRITE, 30, 31, 1'b1));
    send_request(req_of(REQ_WRITE, 31, 30, 1'b1));
    send_request(req_of(REQ_WRITE, 31, 31, 1'b1));
    send_request(req_of(REQ_UNKNOWN, 31, 31, 1'b1));
    send_request(req_of(REQ_READ, 31, 31, 1'b0));
    send_request(req_of(REQ_ADVANCE, 0, 0, 1'b0));
    send_request(req_of(REQ_READ, 0, 1, 1'b0));
    send_request(req_of(REQ_READ, 1, 1, 1'b0));
    send_request(req_of(REQ_READ, 0, 0, 1'b0));
    send_request(req_of(REQ_READ, 31, 1, 1'b0));
    send_request(req_of(REQ_READ, 31, 31, 1'b0));
    send_request(req_of(REQ_READ, 30, 30, 1'b0));
    send_request(req_of(REQ_WRITE, 31, 31, 1'b0));
    send_request(req_of(REQ_READ, 31, 31, 1'b1));
    send_request(req_of(REQ_ADVANCE, 31, 31, 1'b1));
    send_request(req_of(REQ_READ, 31, 31, 1'b0));
    send_request(req_of(REQ_READ, 1, 1, 1'b0));

    // Random part, one phase per idling pattern.
    for (phase = 0; phase < 4; phase++) begin
      sender_idle_pct    = idle_by_phase[phase];
      receiver_stall_pct = stall_by_phase[phase];
      phase_goal = sent_reqs + PHASE_REQS;
      while (sent_reqs < phase_goal) run_episode();
    end
    in_valid_i <= 1'b0;

    // Drain the outstanding acknowledgements, then watch for strays.
    while (grid_tracker.expected_acks.size() != 0) @(posedge clk_i);
    repeat (2 * GRID_SIZE + 8) @(posedge clk_i);

    if (grid_tracker.failures == 0 && grid_tracker.expected_acks.size() == 0) begin
      $display("** life_grid_generation_step: PASSED **");
    end else begin
      $display("** life_grid_generation_step: FAILED **");
    end
    $finish;
  end

  // Ends a run that has hung.
  initial begin
    #(TIMEOUT_NS);
    $display("** life_grid_generation_step: FAILED **");
    $finish;
  end

endmodule
